FILE: src/kmnc_pkg.sv
// kmnc_pkg: shared types, constants and helpers for the nearest-center block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package kmnc_pkg;

  localparam int DEF_MAX_CENTERS = 16;
  localparam int DEF_DIMS        = 16;

  localparam int COORD_W = 16;
  localparam int IDX_W   = 4;
  localparam int WGT_W   = 16;
  localparam int SQ_W    = 32;
  localparam int DIST_W  = 36;
  localparam int PROD_W  = DIST_W + WGT_W;
  localparam int COST_W  = 64;
  localparam int CFG_W   = 5;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [COST_W-1:0] COST_MAX  = '1;

  // register word index, taken from paddr[2]
  localparam logic REG_CENTERS_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_POINT = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [IDX_W-1:0]          center_index;
    logic [IDX_W-1:0]          coord_index;
    logic signed [COORD_W-1:0] coord_value;
    logic [WGT_W-1:0]          point_weight;
    logic                      last_coord;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  nearest_center;
    logic [DIST_W-1:0] min_distance;
    logic [COST_W-1:0] running_cost;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic accept;      // capture point coordinate, restart center counter
    logic load_wr;     // write center coordinate from the input word
    logic clear_cost;
    logic issue;       // read center store for current center, advance
    logic mul;         // weight times best distance
    logic emit;        // load result register, update cost, clear partials
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic issue_last;
    logic out_free;
  } sts_t;

  function automatic int clog2_min1(input int v);
    return (v > 1) ? $clog2(v) : 1;
  endfunction

endpackage

FILE: src/kmnc_ram.sv
// kmnc_ram: generic single write port, single read port ram with registered read
// depends on kmnc_pkg for address width helper
`timescale 1ns / 1ps

module kmnc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [kmnc_pkg::clog2_min1(DEPTH)-1:0]      waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [kmnc_pkg::clog2_min1(DEPTH)-1:0]      raddr,
  output logic [WIDTH-1:0]                            rdata
);
  import kmnc_pkg::*;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/kmnc_ctrl.sv
// kmnc_ctrl: sequencer for loads, clears and per-coordinate center passes
// depends on kmnc_pkg for command and status structs
`timescale 1ns / 1ps

module kmnc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      req_type,
  input  logic            last_coord,
  input  kmnc_pkg::sts_t  sts,
  output logic            in_stall,
  output kmnc_pkg::cmd_t  cmd
);
  import kmnc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_W1,
    ST_W2,
    ST_MUL,
    ST_EMIT
  } state_t;

  state_t state_r;
  logic   last_r;
  logic   acc;

  always_comb begin
    in_stall       = (state_r != ST_IDLE);
    acc            = in_valid && !in_stall;
    cmd.accept     = acc && (req_type == REQ_POINT);
    cmd.load_wr    = acc && (req_type == REQ_LOAD);
    cmd.clear_cost = acc && (req_type == REQ_CLEAR);
    cmd.issue      = (state_r == ST_PASS);
    cmd.mul        = (state_r == ST_MUL);
    cmd.emit       = (state_r == ST_EMIT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cmd.accept) begin
            state_r <= ST_PASS;
            last_r  <= last_coord;
          end
        end
        ST_PASS: begin
          if (sts.issue_last) begin
            state_r <= ST_W1;
          end
        end
        ST_W1: begin
          state_r <= ST_W2;
        end
        // last partial sum and running minimum settle at the end of this cycle
        ST_W2: begin
          state_r <= last_r ? ST_MUL : ST_IDLE;
        end
        ST_MUL: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (sts.out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_pass_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PASS && sts.issue_last) |=> (state_r == ST_W1))
    else $error("center pass did not end after last center");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(cmd.accept))
    else $error("stall raised without a point word accepted");

endmodule

FILE: src/kmnc_datapath.sv
// kmnc_datapath: center store, squared-distance pipeline, running minimum,
// weighted cost accumulator and result register; depends on kmnc_pkg, kmnc_ram
`timescale 1ns / 1ps

module kmnc_datapath #(
  parameter int MAX_CENTERS = kmnc_pkg::DEF_MAX_CENTERS,
  parameter int DIMS        = kmnc_pkg::DEF_DIMS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  kmnc_pkg::cmd_t                 cmd,
  input  kmnc_pkg::in_word_t             in_word,
  input  logic [kmnc_pkg::CFG_W-1:0]     centers_in_use,
  output kmnc_pkg::sts_t                 sts,
  output logic                           out_valid,
  input  logic                           out_stall,
  output kmnc_pkg::out_word_t            out_word
);
  import kmnc_pkg::*;

  localparam int IW    = clog2_min1(MAX_CENTERS);
  localparam int DEPTH = MAX_CENTERS * DIMS;
  localparam int AW    = clog2_min1(DEPTH);

  // captured point coordinate
  logic signed [COORD_W-1:0] x_r;
  logic [IDX_W-1:0]          di_r;
  logic                      di_ok_r;
  logic [WGT_W-1:0]          w_r;

  logic [IW-1:0] cnt_r;
  logic [IW:0]   n_act;
  logic [IW-1:0] last_idx;

  // center store ports
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;
  logic [COORD_W-1:0]    mem_rdata;

  // pipeline stages
  logic                  v1_r;
  logic [IW-1:0]         c1_r;
  logic                  v2_r;
  logic [IW-1:0]         c2_r;
  logic [SQ_W-1:0]       sq_r;
  logic signed [COORD_W:0]     diff;
  logic signed [2*COORD_W+1:0] sq_full;

  logic [DIST_W-1:0]     part_r [MAX_CENTERS];
  logic [MAX_CENTERS-1:0] pvalid_r;
  logic [DIST_W-1:0]     part_old;
  logic [DIST_W:0]       dist_sum;
  logic [DIST_W-1:0]     dist_nxt;

  logic [DIST_W-1:0]     best_d_r;
  logic [IW-1:0]         best_c_r;
  logic [PROD_W-1:0]     prod_r;
  logic [COST_W-1:0]     cost_r;
  logic [COST_W:0]       cost_sum;
  logic [COST_W-1:0]     cost_nxt;

  logic                  out_valid_r;
  out_word_t             out_word_r;

  // active centers clamped to 1..MAX_CENTERS
  always_comb begin
    if (centers_in_use == '0) begin
      n_act = (IW+1)'(1);
    end else if (32'(centers_in_use) > 32'(MAX_CENTERS)) begin
      n_act = (IW+1)'(MAX_CENTERS);
    end else begin
      n_act = (IW+1)'(centers_in_use);
    end
    last_idx = IW'(n_act - (IW+1)'(1));
  end

  assign sts.issue_last = (cnt_r == last_idx);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign mem_we = cmd.load_wr
                  && (32'(in_word.center_index) < 32'(MAX_CENTERS))
                  && (32'(in_word.coord_index) < 32'(DIMS));
  assign mem_waddr = AW'(32'(in_word.center_index) * 32'(DIMS)
                         + 32'(in_word.coord_index));
  assign mem_raddr = AW'(32'(cnt_r) * 32'(DIMS) + 32'(di_r));

  kmnc_ram #(
    .WIDTH (COORD_W),
    .DEPTH (DEPTH)
  ) u_center_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_word.coord_value),
    .re    (cmd.issue),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    diff    = (COORD_W+1)'(x_r) - (COORD_W+1)'($signed(mem_rdata));
    sq_full = (2*COORD_W+2)'(diff) * (2*COORD_W+2)'(diff);
    part_old = pvalid_r[c2_r] ? part_r[c2_r] : '0;
    dist_sum = {1'b0, part_old} + (DIST_W+1)'(sq_r);
    dist_nxt = dist_sum[DIST_W] ? DIST_MAX : dist_sum[DIST_W-1:0];
    cost_sum = {1'b0, cost_r} + (COST_W+1)'(prod_r);
    cost_nxt = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      pvalid_r    <= '0;
      cost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        cnt_r <= '0;
      end else if (cmd.issue) begin
        cnt_r <= cnt_r + IW'(1);
      end
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.emit) begin
        pvalid_r <= '0;
      end else if (v2_r) begin
        pvalid_r[c2_r] <= 1'b1;
      end
      if (cmd.clear_cost) begin
        cost_r <= '0;
      end else if (cmd.emit) begin
        cost_r <= cost_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r     <= in_word.coord_value;
      di_r    <= in_word.coord_index;
      di_ok_r <= (32'(in_word.coord_index) < 32'(DIMS));
      w_r     <= in_word.point_weight;
    end
    c1_r <= cnt_r;
    c2_r <= c1_r;
    // out-of-range dimension adds nothing but still runs the minimum scan
    sq_r <= di_ok_r ? SQ_W'($unsigned(sq_full)) : '0;
    if (v2_r) begin
      part_r[c2_r] <= dist_nxt;
      // strict less keeps the lowest index on ties
      if ((c2_r == '0) || (dist_nxt < best_d_r)) begin
        best_d_r <= dist_nxt;
        best_c_r <= c2_r;
      end
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(best_d_r) * PROD_W'(w_r);
    end
    if (cmd.emit) begin
      out_word_r.nearest_center <= IDX_W'(best_c_r);
      out_word_r.min_distance   <= best_d_r;
      out_word_r.running_cost   <= cost_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!v1_r && !v2_r))
    else $error("result emitted while distance pipeline busy");

  a_cost_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.clear_cost |=> (cost_r >= $past(cost_r)))
    else $error("running cost decreased without a clear");

endmodule

FILE: src/kmeans_nearest_center_assign.sv
// k-means nearest-center assignment, top level: apb register, controller, datapath
// a point coordinate stalls the input through the center pass (n = active centers,
// one center store read per cycle) and states W1 and W2, then the next word is taken;
// a last coordinate also stalls through MUL and EMIT, where EMIT waits for a free output
// and loads the result word; loads and clears do not stall the input; reset clears control,
// cost, partial sums and sets centers_in_use to 16; the center store is not cleared
`timescale 1ns / 1ps

module kmeans_nearest_center_assign #(
  parameter int MAX_CENTERS = kmnc_pkg::DEF_MAX_CENTERS,
  parameter int DIMS        = kmnc_pkg::DEF_DIMS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  kmnc_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output kmnc_pkg::out_word_t           out_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kmnc_pkg::APB_AW-1:0]   paddr,
  input  logic [kmnc_pkg::APB_DW-1:0]   pwdata,
  output logic [kmnc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import kmnc_pkg::*;

  logic [CFG_W-1:0] centers_in_use_r;
  logic             cfg_wr;
  cmd_t             cmd;
  sts_t             sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CENTERS_IN_USE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centers_in_use_r <= CFG_RESET;
    end else if (cfg_wr) begin
      centers_in_use_r <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_CENTERS_IN_USE) begin
      prdata = APB_DW'(centers_in_use_r);
    end else begin
      prdata = '0;
    end
  end

  kmnc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .req_type   (in_word.req_type),
    .last_coord (in_word.last_coord),
    .sts        (sts),
    .in_stall   (in_stall),
    .cmd        (cmd)
  );

  kmnc_datapath #(
    .MAX_CENTERS (MAX_CENTERS),
    .DIMS        (DIMS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_word        (in_word),
    .centers_in_use (centers_in_use_r),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word)
  );

endmodule
